// ===== rtl/core/amgr_pkg.sv =====
// Shared types, constants and font table of the millivolt glyph renderer.
package amgr_pkg;

   localparam logic [7:0] PAGE_BASE        = 8'hB0;
   localparam logic [7:0] PAGE_SIGN        = 8'hB7;
   localparam logic [4:0] COLUMN_HIGH_BASE = 5'h10;
   localparam logic [6:0] COLUMN_MAX       = 7'd101;
   localparam logic [3:0] GLYPH_PLUS       = 4'd0;

   typedef logic [103:0] glyph_type;

   // Decimal digits of one reading, least significant first.
   typedef struct packed {
      logic [2:0]       digit_count;
      logic [3:0][3:0]  digits;
   } digit_entry_type;

   // Glyph 0 is the plus sign, glyphs 1..10 are the digits 0..9.
   function automatic glyph_type font_glyph(input logic [3:0] index);
      glyph_type bits;
      case (index)
         4'd1:    bits = 104'h70_F8_D8_D8_D8_D8_D8_D8_D8_D8_D8_F8_70;
         4'd2:    bits = 104'h18_38_78_D8_98_18_18_18_18_18_18_18_18;
         4'd3:    bits = 104'h70_F8_D8_D8_18_18_38_70_E0_C0_C0_F8_F8;
         4'd4:    bits = 104'h70_F8_D8_18_18_F8_F8_18_18_18_D8_F8_70;
         4'd5:    bits = 104'hD8_D8_D8_D8_D8_D8_F8_F8_18_18_18_18_18;
         4'd6:    bits = 104'hF8_F8_C0_C0_C0_F0_F8_D8_18_18_D8_F8_70;
         4'd7:    bits = 104'h70_F8_D8_C0_C0_F0_F8_D8_D8_D8_D8_F8_70;
         4'd8:    bits = 104'hF8_F8_18_18_18_38_70_E0_C0_C0_C0_C0_C0;
         4'd9:    bits = 104'h70_F8_D8_D8_D8_F8_70_D8_D8_D8_D8_F8_70;
         4'd10:   bits = 104'h70_F8_D8_D8_D8_F8_78_18_18_18_38_70_E0;
         default: bits = 104'h20_20_20_20_20_F8_F8_F8_20_20_20_20_20;
      endcase
      return bits;
   endfunction

endpackage

// ===== rtl/core/adc_millivolt_glyph_renderer.sv =====
// Top level of the millivolt glyph renderer: column register, front, queue and back.
//
// Usage:
//   req_*  : one 12-bit converter sample per word. The value is scaled to
//            millivolts (0..1499) and split into decimal digits.
//   rsp_*  : display groups, one per word: first a plus sign on page 0xB7,
//            then one group per digit, most significant first, no leading
//            zeros. rsp_last_group marks the final digit group of a sample.
//   csr_*  : start column, always ready; values above 101 are clamped. Write
//            it only while no sample is in flight.
// Path: after acceptance, the first group of a sample passes front stages 2..4,
//   the queue, the current-sample register and the output register.
// Throughput: while the receiver is ready, the back emits one group per cycle;
//   a sample has 2 to 5 groups, its digit count plus one; the front takes a
//   sample every cycle while the two-entry queue has room.
// Reset (synchronous, active high) empties the pipeline and queue and sets
//   the start column to 0.
// A stalled receiver holds the registered group; the back then stops, the
//   queue fills and req_ready drops once the last front stage waits on it.
module adc_millivolt_glyph_renderer
   import amgr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_page_command,
   output logic [3:0]  rsp_column_low_command,
   output logic [4:0]  rsp_column_high_command,
   output logic [63:0] rsp_glyph_head,
   output logic [39:0] rsp_glyph_tail,
   output logic        rsp_last_group,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_column_start
);

   logic [6:0]      column_ff;
   logic [6:0]      column_clamped;
   logic            push_valid;
   digit_entry_type push_entry;
   logic            queue_full;
   logic            pop;
   logic            pop_valid;
   digit_entry_type pop_entry;

   // Column register; the write port never stalls.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= 7'd0;
      end else if (csr_valid) begin
         column_ff <= csr_column_start;
      end
   end

   // Clamp once here so the back only splits the column into nibbles.
   assign column_clamped = (column_ff > COLUMN_MAX) ? COLUMN_MAX : column_ff;

   amgr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   amgr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   amgr_back u_back (
      .clock                   (clock),
      .reset                   (reset),
      .pop_valid               (pop_valid),
      .pop_entry               (pop_entry),
      .pop                     (pop),
      .column                  (column_clamped),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_page_command        (rsp_page_command),
      .rsp_column_low_command  (rsp_column_low_command),
      .rsp_column_high_command (rsp_column_high_command),
      .rsp_glyph_head          (rsp_glyph_head),
      .rsp_glyph_tail          (rsp_glyph_tail),
      .rsp_last_group          (rsp_last_group)
   );

`ifndef ASSERT_OFF
   // The sign group is never the final group of a sample.
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_group |-> rsp_page_command != PAGE_SIGN)
      else $error("sign group flagged as last");

   // Groups of one sample follow without gaps.
   a_groups_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_group |=> rsp_valid)
      else $error("gap inside a sample's groups");

   // Each following group sits one page lower.
   a_page_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_group |=>
         rsp_page_command == $past(rsp_page_command) - 8'd1)
      else $error("page command out of sequence");

   // The emitted column never passes the clamp.
   a_column_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_column_high_command == 5'h10 || rsp_column_high_command == 5'h11 ||
                     rsp_column_high_command == 5'h12 || rsp_column_high_command == 5'h13 ||
                     rsp_column_high_command == 5'h14 || rsp_column_high_command == 5'h15 ||
                     (rsp_column_high_command == 5'h16 && rsp_column_low_command <= 4'd5)))
      else $error("column beyond clamp");
`endif

endmodule

// ===== rtl/core/amgr_front.sv =====
// Front pipeline: scale a sample to millivolts and split it into decimal digits.
module amgr_front
   import amgr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [11:0]     req_sample,
   output logic            push_valid,
   output digit_entry_type push_entry,
   input  logic            queue_full
);

   localparam logic [20:0] MV_SCALE   = 21'd375;
   localparam logic [10:0] THOUSAND   = 11'd1000;
   localparam logic [15:0] HUND_RECIP = 16'd41;
   localparam logic [9:0]  HUNDRED    = 10'd100;
   localparam logic [13:0] TEN_RECIP  = 14'd103;
   localparam logic [6:0]  TEN        = 7'd10;

   logic        advance;
   logic [20:0] scaled;
   logic [9:0]  rest_in;
   logic [15:0] hund_prod;
   logic [9:0]  hund_val;
   logic [9:0]  rest2_full;
   logic [13:0] tens_prod;
   logic [6:0]  tens_val;
   logic [6:0]  ones_full;

   logic        s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [10:0] s1_mv_ff;
   logic        s2_thousands_ff, s3_thousands_ff, s4_thousands_ff;
   logic [9:0]  s2_rest_ff;
   logic [3:0]  s2_hundreds_ff, s3_hundreds_ff, s4_hundreds_ff;
   logic [6:0]  s3_rest_ff, s4_rest_ff;
   logic [3:0]  s4_tens_ff;

   // Whole pipeline moves together; stall only when the last stage cannot push.
   assign advance    = !s4_valid_ff || !queue_full;
   assign req_ready  = advance;
   assign push_valid = s4_valid_ff && !queue_full;

   assign scaled    = {9'd0, req_sample} * MV_SCALE;
   assign rest_in   = (s1_mv_ff >= THOUSAND) ? 10'(s1_mv_ff - THOUSAND) : s1_mv_ff[9:0];
   assign hund_prod = {6'd0, rest_in} * HUND_RECIP;
   assign hund_val  = {6'd0, s2_hundreds_ff} * HUNDRED;
   assign rest2_full = s2_rest_ff - hund_val;
   assign tens_prod = {7'd0, s3_rest_ff} * TEN_RECIP;
   assign tens_val  = {3'd0, s4_tens_ff} * TEN;
   assign ones_full = s4_rest_ff - tens_val;

   always_comb begin
      push_entry.digits[3] = {3'd0, s4_thousands_ff};
      push_entry.digits[2] = s4_hundreds_ff;
      push_entry.digits[1] = s4_tens_ff;
      push_entry.digits[0] = ones_full[3:0];
      if (s4_thousands_ff) begin
         push_entry.digit_count = 3'd4;
      end else if (s4_hundreds_ff != 4'd0) begin
         push_entry.digit_count = 3'd3;
      end else if (s4_tens_ff != 4'd0) begin
         push_entry.digit_count = 3'd2;
      end else begin
         push_entry.digit_count = 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mv_ff        <= scaled[20:10];
         s2_thousands_ff <= (s1_mv_ff >= THOUSAND);
         s2_rest_ff      <= rest_in;
         s2_hundreds_ff  <= hund_prod[15:12];
         s3_thousands_ff <= s2_thousands_ff;
         s3_hundreds_ff  <= s2_hundreds_ff;
         s3_rest_ff      <= rest2_full[6:0];
         s4_thousands_ff <= s3_thousands_ff;
         s4_hundreds_ff  <= s3_hundreds_ff;
         s4_rest_ff      <= s3_rest_ff;
         s4_tens_ff      <= tens_prod[13:10];
      end
   end

endmodule

// ===== rtl/core/amgr_queue.sv =====
// Two-entry queue of digit words between the front and back parts.
module amgr_queue
   import amgr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   input  digit_entry_type push_entry,
   output logic            full,
   input  logic            pop,
   output logic            pop_valid,
   output digit_entry_type pop_entry
);

   digit_entry_type slot_ff [2];
   logic            wr_ptr_ff, rd_ptr_ff;
   logic [1:0]      count_ff;
   logic [1:0]      count_in;
   logic            do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      count_in = count_ff;
      if (push_valid && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !push_valid) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push_valid) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/amgr_back.sv =====
// Back part: walk the groups of one reading and drive the registered result word.
module amgr_back
   import amgr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            pop_valid,
   input  digit_entry_type pop_entry,
   output logic            pop,
   input  logic [6:0]      column,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [7:0]      rsp_page_command,
   output logic [3:0]      rsp_column_low_command,
   output logic [4:0]      rsp_column_high_command,
   output logic [63:0]     rsp_glyph_head,
   output logic [39:0]     rsp_glyph_tail,
   output logic            rsp_last_group
);

   digit_entry_type cur_ff;
   logic            cur_valid_ff, cur_valid_in;
   logic [2:0]      group_ff, group_in;
   logic            rsp_valid_ff;
   logic [7:0]      page_ff;
   logic [3:0]      col_low_ff;
   logic [4:0]      col_high_ff;
   glyph_type       glyph_ff;
   logic            last_ff;

   logic            load;
   logic            finish;
   logic [2:0]      digit_pos;
   logic [3:0]      glyph_index;
   glyph_type       glyph_bits;

   assign load   = !rsp_valid_ff || rsp_ready;
   assign finish = cur_valid_ff && load && (group_ff == cur_ff.digit_count);
   assign pop    = pop_valid && (!cur_valid_ff || finish);

   // Digits are stored least significant first; group 1 shows the top one.
   assign digit_pos   = cur_ff.digit_count - group_ff;
   assign glyph_index = (group_ff == 3'd0) ? GLYPH_PLUS
                                           : cur_ff.digits[digit_pos[1:0]] + 4'd1;
   assign glyph_bits  = font_glyph(glyph_index);

   always_comb begin
      cur_valid_in = cur_valid_ff;
      group_in     = group_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         group_in     = 3'd0;
      end else if (finish) begin
         cur_valid_in = 1'b0;
      end else if (cur_valid_ff && load) begin
         group_in = group_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         group_ff     <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         group_ff     <= group_in;
         if (load) begin
            rsp_valid_ff <= cur_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= pop_entry;
      end
      if (load && cur_valid_ff) begin
         page_ff     <= PAGE_BASE + 8'd7 - {5'd0, group_ff};
         col_low_ff  <= column[3:0];
         col_high_ff <= COLUMN_HIGH_BASE + {2'd0, column[6:4]};
         glyph_ff    <= glyph_bits;
         last_ff     <= (group_ff != 3'd0) && (group_ff == cur_ff.digit_count);
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_page_command        = page_ff;
   assign rsp_column_low_command  = col_low_ff;
   assign rsp_column_high_command = col_high_ff;
   assign rsp_glyph_head          = glyph_ff[103:40];
   assign rsp_glyph_tail          = glyph_ff[39:0];
   assign rsp_last_group          = last_ff;

endmodule
